FILE: hdl/sseg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_pkg
// Shared types, constants and segment tables for the seven-segment shift-out.
// ----------------------------------------------------------------------------
package sseg_pkg;

  localparam int ValueW    = 14;
  localparam int DigitW    = 4;
  localparam int NumDigits = 4;
  localparam int BcdW      = DigitW * NumDigits;
  localparam int CodeW     = 8;
  localparam int CodesW    = CodeW * NumDigits;
  localparam int CntW      = 6;

  localparam logic [ValueW-1:0] MaxValue = ValueW'(9999);

  typedef logic [CodesW-1:0] codes_t;

  // one queue entry: four digit codes, ones code in the lowest byte
  typedef struct packed {
    logic   valid;
    codes_t codes;
  } sseg_entry_t;

  // normal active-low segment table
  function automatic logic [CodeW-1:0] seg_normal(input logic [DigitW-1:0] d);
    logic [CodeW-1:0] c;
    case (d)
      4'd0:    c = 8'd192;
      4'd1:    c = 8'd249;
      4'd2:    c = 8'd164;
      4'd3:    c = 8'd176;
      4'd4:    c = 8'd153;
      4'd5:    c = 8'd146;
      4'd6:    c = 8'd130;
      4'd7:    c = 8'd248;
      4'd8:    c = 8'd128;
      4'd9:    c = 8'd144;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // upside-down active-low segment table
  function automatic logic [CodeW-1:0] seg_flipped(input logic [DigitW-1:0] d);
    logic [CodeW-1:0] c;
    case (d)
      4'd0:    c = 8'd192;
      4'd1:    c = 8'd207;
      4'd2:    c = 8'd164;
      4'd3:    c = 8'd134;
      4'd4:    c = 8'd139;
      4'd5:    c = 8'd146;
      4'd6:    c = 8'd144;
      4'd7:    c = 8'd199;
      4'd8:    c = 8'd128;
      4'd9:    c = 8'd130;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/sseg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_front
// Accepts a value, saturates it, converts it to decimal digits by shift-add-3
// and pushes the four segment codes into the queue.
// ----------------------------------------------------------------------------
module sseg_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sseg_pkg::ValueW-1:0] in_value_i,
  output sseg_pkg::sseg_entry_t      push_o,
  input  logic                       push_ready_i
);
  import sseg_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StPush
  } state_e;

  localparam int StepW = $clog2(ValueW + 1);

  state_e            state_q;
  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [StepW-1:0]  step_q;
  logic [BcdW-1:0]   bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      logic [DigitW-1:0] dig;
      dig = bcd_q[i*DigitW +: DigitW];
      bcd_adj[i*DigitW +: DigitW] = (dig >= DigitW'(5)) ? dig + DigitW'(3) : dig;
    end
    bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
    bin_d = {bin_q[ValueW-2:0], 1'b0};
  end

  // conversion sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StConv;
            step_q  <= '0;
          end
        end
        StConv: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(ValueW - 1)) begin
            state_q <= StPush;
          end
        end
        StPush: begin
          if (push_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      bin_q <= (in_value_i > MaxValue) ? MaxValue : in_value_i;
      bcd_q <= '0;
    end else if (state_q == StConv) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  // segment lookup on the finished digits
  assign push_o.valid = (state_q == StPush);
  assign push_o.codes = {seg_normal(bcd_q[3*DigitW +: DigitW]),
                         seg_normal(bcd_q[2*DigitW +: DigitW]),
                         seg_flipped(bcd_q[1*DigitW +: DigitW]),
                         seg_flipped(bcd_q[0 +: DigitW])};

endmodule

FILE: hdl/sseg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_fifo
// Two-entry queue of code sets between the front and the serializer.
// ----------------------------------------------------------------------------
module sseg_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sseg_pkg::sseg_entry_t push_i,
  output logic                  push_ready_o,
  output sseg_pkg::sseg_entry_t head_o,
  input  logic                  pop_i
);
  import sseg_pkg::*;

  codes_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && (count_q != 2'd0);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.codes;
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.codes = mem_q[rd_ptr_q];

endmodule

FILE: hdl/sseg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_back
// Serializes one code set into 64 shift results: all-lit code zero first, then
// the digit codes, MSB first, with latch and last marks.
// ----------------------------------------------------------------------------
module sseg_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sseg_pkg::sseg_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_channel_o,
  output logic                  out_data_bit_o,
  output logic                  out_latch_o,
  output logic                  out_last_o
);
  import sseg_pkg::*;

  logic [CntW-1:0]  k_q;
  logic             valid_q;
  logic [1:0]       chan_q;
  logic             bit_q, latch_q, last_q;
  logic             advance;
  logic [1:0]       chan;
  logic [2:0]       bidx;
  logic [CodeW-1:0] code;
  logic             dbit;

  assign advance = head_i.valid && (!valid_q || out_ready_i);
  assign pop_o   = advance && (k_q == '1);

  // pick the current bit: first half sends all-lit code zero
  assign chan = k_q[4:3];
  assign bidx = 3'd7 - k_q[2:0];
  assign code = head_i.codes[chan*CodeW +: CodeW];
  assign dbit = k_q[CntW-1] ? code[bidx] : 1'b0;

  // bit counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      if (advance) begin
        k_q     <= k_q + CntW'(1);
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      chan_q  <= chan;
      bit_q   <= dbit;
      latch_q <= (k_q[2:0] == 3'd7);
      last_q  <= (k_q == '1);
    end
  end

  assign out_valid_o    = valid_q;
  assign out_channel_o  = chan_q;
  assign out_data_bit_o = bit_q;
  assign out_latch_o    = latch_q;
  assign out_last_o     = last_q;

endmodule

FILE: hdl/four_digit_seven_segment_shiftout_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_seven_segment_shiftout_unit
// Converts a number to four seven-segment codes and shifts them out serially.
// ----------------------------------------------------------------------------
// Each accepted value (saturated at 9999) yields 64 shift results, one per
// cycle while the output side is ready: eight codes of eight bits, MSB first,
// to channels 0..3 twice, all-lit code zero first and then the digit codes
// (ones and tens upside down). The serializer sets the sustained rate; while it
// shifts out one value the front already takes the next (accept, 14 conversion
// steps, queue push), and a two-entry queue holds finished code sets.
module four_digit_seven_segment_shiftout_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [13:0] value, [15:14] zero
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,   // [1:0] channel, [2] data_bit, [3] latch_after, [7:4] zero
  output logic        m_tlast_o    // last
);
  import sseg_pkg::*;

  sseg_entry_t push, head;
  logic        push_ready, pop;
  logic [1:0]  channel;
  logic        data_bit, latch_after;

  // front: accept, saturate, convert
  sseg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .in_value_i   (s_tdata_i[ValueW-1:0]),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // queue between the two sides
  sseg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: serializer
  sseg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_tvalid_o),
    .out_ready_i    (m_tready_i),
    .out_channel_o  (channel),
    .out_data_bit_o (data_bit),
    .out_latch_o    (latch_after),
    .out_last_o     (m_tlast_o)
  );

  assign m_tdata_o = {4'b0000, latch_after, data_bit, channel};

`ifndef NO_ASSERTIONS
  // the final result is the eighth bit to the thousands chain
  a_last_is_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tdata_o[3] && (m_tdata_o[1:0] == 2'd3))
    else $error("last result is not a latched bit of channel 3");

  // a code set waiting for queue space keeps its value
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid && !push_ready |=> push.valid && $stable(push.codes))
    else $error("pending code set changed while queue full");

  // the serializer releases a queue entry only on its last bit
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_tvalid_o && m_tlast_o)
    else $error("queue entry released before final result");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-digit seven-segment shift-out unit.
// ----------------------------------------------------------------------------
// A directed table and then random values are sent as requests. Each accepted
// value is turned into its 64 expected shift bits: the all-lit code zero to
// channels 0..3, then the digit codes, MSB first. Every output beat is
// compared with the oldest pending bit. Both sides idle at random, and the
// sender drains the unit completely now and then.
// ----------------------------------------------------------------------------
module tb;
  import sseg_pkg::*;

  localparam int BitsPerValue = 64;
  localparam int NumRandom    = 427;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 100;
  localparam int MaxReports   = 10;

  // one expected shift beat
  typedef struct packed {
    logic [1:0] channel;
    logic       data_bit;
    logic       latch_after;
    logic       last;
  } shift_bit_t;

  // directed row: typed rows carry their digit codes, ones code lowest
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              typed;
    logic [31:0]       codes;
  } value_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_tvalid_i;
  logic              s_tready_o;
  logic [15:0]       s_tdata_i;
  logic              m_tvalid_o;
  logic              m_tready_i;
  logic [7:0]        m_tdata_o;
  logic              m_tlast_o;

  // active-low segment tables, digits 0..9
  logic [7:0] upright_seg [0:9] = '{8'd192, 8'd249, 8'd164, 8'd176, 8'd153,
                                    8'd146, 8'd130, 8'd248, 8'd128, 8'd144};
  logic [7:0] flipped_seg [0:9] = '{8'd192, 8'd207, 8'd164, 8'd134, 8'd139,
                                    8'd146, 8'd144, 8'd199, 8'd128, 8'd130};

  shift_bit_t pending_bits [$];
  int unsigned mismatch_count;
  int unsigned bits_checked;
  int unsigned values_sent;
  int unsigned saturated_sent;
  int unsigned idle_cycles;

  four_digit_seven_segment_shiftout_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),   // [13:0] value, [15:14] zero
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),   // [1:0] channel, [2] data_bit, [3] latch_after, [7:4] zero
    .m_tlast_o  (m_tlast_o)    // last
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // digit codes of a value after saturation, ones code in the lowest byte
  function automatic logic [31:0] value_to_codes(input logic [ValueW-1:0] value);
    int v;
    v = (value > 9999) ? 9999 : int'(value);
    return {upright_seg[(v / 1000) % 10], upright_seg[(v / 100) % 10],
            flipped_seg[(v / 10) % 10], flipped_seg[v % 10]};
  endfunction

  // expand a code set into the 64 beats it shifts out
  task automatic queue_shift_bits(input logic [31:0] codes);
    shift_bit_t sb;
    logic [7:0] code;
    int c;
    for (int k = 0; k < BitsPerValue; k++) begin
      c = k / 8;
      code = (c < 4) ? 8'd0 : codes[(c-4)*8 +: 8];
      sb.channel     = 2'(c & 3);
      sb.data_bit    = code[7 - (k % 8)];
      sb.latch_after = ((k % 8) == 7);
      sb.last        = (k == BitsPerValue - 1);
      pending_bits.push_back(sb);
    end
  endtask

  // send one request and queue its expected beats once accepted
  task automatic send_value(input logic [ValueW-1:0] value, input logic typed,
                            input logic [31:0] codes);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {2'b00, value};
    do @(posedge clk_i); while (!s_tready_o);
    queue_shift_bits(typed ? codes : value_to_codes(value));
    values_sent++;
    if (value > 9999) saturated_sent++;
  endtask

  // random value: mostly in range, some saturating, some near digit edges
  function automatic logic [ValueW-1:0] random_value();
    int pick;
    int edges [10] = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000, 16383};
    pick = $urandom_range(0, 9);
    if (pick <= 5) return ValueW'($urandom_range(0, 9999));
    if (pick <= 7) return ValueW'($urandom_range(10000, 16383));
    if (pick == 8) return ValueW'($urandom_range(0, 120));
    return ValueW'(edges[$urandom_range(0, 9)]);
  endfunction

  // output side stall pattern: phases of free flow, coin flips, sparse and long stalls
  initial begin
    int mode;
    int len;
    int phase;
    m_tready_i = 1'b0;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(16, 160);
      repeat (len) begin
        @(posedge clk_i);
        phase++;
        case (mode)
          0: begin
            m_tready_i <= 1'b1;
          end
          1: begin
            m_tready_i <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_tready_i <= ((phase % 4) == 0);
          end
          default: begin
            m_tready_i <= ((phase % 16) >= 10);
          end
        endcase
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    shift_bit_t exp_bit;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      bits_checked++;
      if (pending_bits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected beat: ch=%0d bit=%0d latch=%0d last=%0d",
                   m_tdata_o[1:0], m_tdata_o[2], m_tdata_o[3], m_tlast_o);
      end else begin
        exp_bit = pending_bits.pop_front();
        if (m_tdata_o[1:0] !== exp_bit.channel || m_tdata_o[2] !== exp_bit.data_bit ||
            m_tdata_o[3] !== exp_bit.latch_after || m_tlast_o !== exp_bit.last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $write("beat %0d mismatch: exp ch=%0d bit=%0d latch=%0d last=%0d",
                   bits_checked, exp_bit.channel, exp_bit.data_bit,
                   exp_bit.latch_after, exp_bit.last);
            $display(", got ch=%0d bit=%0d latch=%0d last=%0d", m_tdata_o[1:0],
                     m_tdata_o[2], m_tdata_o[3], m_tlast_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("no handshake for %0d cycles, %0d beats still pending",
               StallLimit, pending_bits.size());
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    value_row_t rows [$];
    value_row_t row;
    int burst_left;
    int gap;
    int total;
    int drain_a;
    int drain_b;

    rst_ni         = 1'b0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    mismatch_count = 0;
    bits_checked   = 0;
    values_sent    = 0;
    saturated_sent = 0;
    idle_cycles    = 0;

    // directed rows: extremes, saturation, every digit in every place, digit edges
    rows.push_back('{value: 14'd0,     typed: 1'b1, codes: 32'hC0C0C0C0});
    rows.push_back('{value: 14'd9999,  typed: 1'b1, codes: 32'h90908282});
    rows.push_back('{value: 14'd10000, typed: 1'b1, codes: 32'h90908282});
    rows.push_back('{value: 14'd16383, typed: 1'b1, codes: 32'h90908282});
    rows.push_back('{value: 14'd10922, typed: 1'b1, codes: 32'h90908282});
    for (int d = 1; d <= 8; d++)
      rows.push_back('{value: ValueW'(1111 * d), typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd9,    typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd10,   typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd99,   typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd100,  typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd999,  typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd1000, typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd1234, typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd9876, typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd5461, typed: 1'b0, codes: '0});
    rows.push_back('{value: 14'd8191, typed: 1'b0, codes: '0});

    // random part follows the table
    for (int i = 0; i < NumRandom; i++)
      rows.push_back('{value: random_value(), typed: 1'b0, codes: '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    total      = rows.size();
    drain_a    = $urandom_range(100, 200);
    drain_b    = $urandom_range(300, 400);
    burst_left = 0;
    for (int i = 0; i < total; i++) begin
      // full drain of the unit before continuing
      if (i == drain_a || i == drain_b) begin
        s_tvalid_i <= 1'b0;
        while (pending_bits.size() != 0) @(posedge clk_i);
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
      // bursts with random gaps, about a third of them back to back
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
        if (gap > 0) begin
          s_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      row = rows[i];
      send_value(row.value, row.typed, row.codes);
    end
    s_tvalid_i <= 1'b0;

    // wait for the tail, then look for stray beats
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d values (%0d above range), checked %0d shift beats",
             values_sent, saturated_sent, bits_checked);
    $display("mismatching beats: %0d", mismatch_count);
    if (mismatch_count == 0 && pending_bits.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
